[src/fd_pkg.sv]
`default_nettype none
package fd_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;
  localparam logic [7:0] FTR_FIRST  = 8'h55;
  localparam logic [7:0] FTR_SECOND = 8'hAA;

  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_MAX_LEN = 3'd0;

  typedef enum logic [1:0] {
    KIND_BODY   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_HEADER = 3'd1,
    ERR_ZERO   = 3'd2,
    ERR_LONG   = 3'd3,
    ERR_FOOTER = 3'd4
  } err_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       opcode;
    logic       last;
    err_t       err;
  } res_t;

endpackage
`default_nettype wire

[src/fd_cfg.sv]
`default_nettype none
module fd_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [fd_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output logic      [15:0]               max_len
);
  import fd_pkg::*;

  logic [15:0] max_len_r;
  logic [15:0] max_len_nxt;
  logic        wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready && (paddr == REG_MAX_LEN);
  assign max_len = max_len_r;

  always_comb begin
    max_len_nxt = max_len_r;
    if (wr_en) begin
      max_len_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr == REG_MAX_LEN) begin
      prdata = {16'd0, max_len_r};
    end
  end

endmodule
`default_nettype wire

[src/fd_parse.sv]
`default_nettype none
module fd_parse (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         byte_vld,
  input  wire logic [7:0]   rx_byte,
  input  wire logic [15:0]  max_len,
  output logic              res_vld,
  output fd_pkg::res_t      res
);
  import fd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEAD0, PH_HEAD1, PH_LENLO, PH_LENHI, PH_BODY, PH_FOOT0, PH_FOOT1, PH_HALT
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [7:0]  ftr_r, ftr_nxt;
  logic        at_op_r, at_op_nxt;
  logic [15:0] len;

  assign len = {rx_byte, len_lo_r};

  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    len_lo_nxt = len_lo_r;
    ftr_nxt    = ftr_r;
    at_op_nxt  = at_op_r;
    res_vld    = 1'b0;
    res        = '{kind: KIND_BODY, data: 8'd0, opcode: 1'b0, last: 1'b0, err: ERR_NONE};
    if (byte_vld) begin
      case (phase_r)
        PH_HEAD0: begin
          if (rx_byte != HDR_FIRST) begin
            res_vld = 1'b1;
            res.kind = KIND_ERROR;
            res.err = ERR_HEADER;
            phase_nxt = PH_HALT;
          end else begin
            phase_nxt = PH_HEAD1;
          end
        end
        PH_HEAD1: begin
          if (rx_byte != HDR_SECOND) begin
            res_vld = 1'b1;
            res.kind = KIND_ERROR;
            res.err = ERR_HEADER;
            phase_nxt = PH_HALT;
          end else begin
            phase_nxt = PH_LENLO;
          end
        end
        PH_LENLO: begin
          len_lo_nxt = rx_byte;
          phase_nxt  = PH_LENHI;
        end
        PH_LENHI: begin
          if (len == 16'd0) begin
            res_vld = 1'b1;
            res.kind = KIND_ERROR;
            res.err = ERR_ZERO;
            phase_nxt = PH_HALT;
          end else if (len > max_len) begin
            res_vld = 1'b1;
            res.kind = KIND_ERROR;
            res.err = ERR_LONG;
            phase_nxt = PH_HALT;
          end else begin
            left_nxt  = len;
            at_op_nxt = 1'b1;
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          res_vld    = 1'b1;
          res.data   = rx_byte;
          res.opcode = at_op_r;
          res.last   = (left_r <= 16'd1);
          left_nxt   = (left_r == 16'd0) ? 16'd0 : left_r - 16'd1;
          at_op_nxt  = 1'b0;
          if (left_r <= 16'd1) begin
            phase_nxt = PH_FOOT0;
          end
        end
        PH_FOOT0: begin
          ftr_nxt   = rx_byte;
          phase_nxt = PH_FOOT1;
        end
        PH_FOOT1: begin
          res_vld = 1'b1;
          if (ftr_r != FTR_FIRST || rx_byte != FTR_SECOND) begin
            res.kind  = KIND_ERROR;
            res.err   = ERR_FOOTER;
            phase_nxt = PH_HALT;
          end else begin
            res.kind  = KIND_ACCEPT;
            at_op_nxt = 1'b1;
            phase_nxt = PH_HEAD0;
          end
        end
        default: begin
          phase_nxt = PH_HALT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEAD0;
      left_r   <= 16'd0;
      len_lo_r <= 8'd0;
      ftr_r    <= 8'd0;
      at_op_r  <= 1'b1;
    end else begin
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      len_lo_r <= len_lo_nxt;
      ftr_r    <= ftr_nxt;
      at_op_r  <= at_op_nxt;
    end
  end

endmodule
`default_nettype wire

[src/fd_obuf.sv]
`default_nettype none
module fd_obuf (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire fd_pkg::res_t push_res,
  output logic              has_room,
  output logic              head_vld,
  output fd_pkg::res_t      head_res,
  input  wire logic         pop
);
  import fd_pkg::*;

  res_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign has_room = (cnt_r != 2'd2);
  assign head_vld = (cnt_r != 2'd0);
  assign head_res = ent_r[rd_ptr_r];
  assign do_pop   = pop && head_vld;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_res;
    end
  end

endmodule
`default_nettype wire

[src/frame_deframer.sv]
// frame_deframer: splits a received byte stream into frames of the form
// header AA 55, 16-bit little-endian body length, body, footer 55 AA.
// Input stream: one byte per transaction on in_tdata.
// Output stream: one transaction per body byte (kind 0, opcode flagged on
// the first body byte, tlast on the final one), one per good footer (kind 1)
// and one for a framing error (kind 2 with error code), after which all
// further bytes are swallowed until reset.
// APB port: register 0 (byte address 0) is max_body_length, 16 bits.
// Results are formed combinationally from each accepted byte and registered
// in the output buffer. Throughput: one byte per cycle while in_tready is
// high, set by the frame state registers that update on every accepted byte.
// The output side is a 2-entry buffer; in_tready drops only when both
// entries hold results that the receiver has not taken, so a stall on the
// output halts input after at most two pending results.
// Reset (rst_n low, synchronous) empties the buffer, returns to waiting for
// the first header byte and sets max_body_length to 4096.
`default_nettype none
module frame_deframer (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [7:0]                in_tdata,   // [7:0] rx_byte
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic      [15:0]               out_tdata,  // [7:0] data_byte, [10:8] error_code
  output logic      [2:0]                out_tuser,  // [1:0] result_kind, [2] is_opcode
  output logic                           out_tlast,  // is_last_body
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [fd_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready
);
  import fd_pkg::*;

  logic [15:0] max_len;
  logic        res_vld;
  res_t        res;
  logic        has_room;
  res_t        head_res;
  logic        in_acc;

  assign in_tready = has_room;
  assign in_acc    = in_tvalid && in_tready;

  fd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  fd_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_acc),
    .rx_byte  (in_tdata),
    .max_len  (max_len),
    .res_vld  (res_vld),
    .res      (res)
  );

  fd_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_vld),
    .push_res (res),
    .has_room (has_room),
    .head_vld (out_tvalid),
    .head_res (head_res),
    .pop      (out_tready)
  );

  assign out_tdata = {5'd0, head_res.err, head_res.data};
  assign out_tuser = {head_res.opcode, head_res.kind};
  assign out_tlast = head_res.last;

endmodule
`default_nettype wire

[sim/tb_frame_deframer.sv]
`timescale 1ns / 100ps
module tb_frame_deframer;
  import fd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [2:0] {
    RX_HEAD0, RX_HEAD1, RX_LENLO, RX_LENHI, RX_BODY, RX_FOOT0, RX_FOOT1, RX_HALT
  } rx_phase_t;

  class frame_tracker;
    logic [15:0] max_len;
    rx_phase_t   ph;
    logic [15:0] left;
    logic [7:0]  len_lo;
    logic [7:0]  foot_lo;
    bit          first_body;
    res_t        due_results[$];
    int          errors;

    function new();
      max_len    = MAX_LEN_RESET;
      ph         = RX_HEAD0;
      left       = '0;
      len_lo     = '0;
      foot_lo    = '0;
      first_body = 1'b1;
      errors     = 0;
    endfunction

    function void mismatch(string what, int exp_v, int act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    endfunction

    function void halt_with(err_t code);
      res_t r;
      r      = '0;
      r.kind = KIND_ERROR;
      r.err  = code;
      ph     = RX_HALT;
      due_results.push_back(r);
    endfunction

    // one accepted input transaction
    function void advance_rx(logic [7:0] b);
      res_t        r;
      logic [15:0] n;
      r = '0;
      case (ph)
        RX_HEAD0: begin
          if (b != HDR_FIRST) halt_with(ERR_HEADER);
          else ph = RX_HEAD1;
        end
        RX_HEAD1: begin
          if (b != HDR_SECOND) halt_with(ERR_HEADER);
          else ph = RX_LENLO;
        end
        RX_LENLO: begin
          len_lo = b;
          ph = RX_LENHI;
        end
        RX_LENHI: begin
          n = {b, len_lo};
          if (n == 16'd0) halt_with(ERR_ZERO);
          else if (n > max_len) halt_with(ERR_LONG);
          else begin
            left = n;
            first_body = 1'b1;
            ph = RX_BODY;
          end
        end
        RX_BODY: begin
          r.kind   = KIND_BODY;
          r.data   = b;
          r.opcode = first_body;
          r.last   = (left <= 16'd1);
          if (left != 16'd0) left = left - 16'd1;
          first_body = 1'b0;
          if (left == 16'd0) ph = RX_FOOT0;
          due_results.push_back(r);
        end
        RX_FOOT0: begin
          foot_lo = b;
          ph = RX_FOOT1;
        end
        RX_FOOT1: begin
          if (foot_lo != FTR_FIRST || b != FTR_SECOND) halt_with(ERR_FOOTER);
          else begin
            ph = RX_HEAD0;
            first_body = 1'b1;
            r.kind = KIND_ACCEPT;
            due_results.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    // one accepted output transaction
    function void check_out(res_t got);
      res_t e;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d data %0d err %0d",
                 $time, got.kind, got.data, got.err);
      end else begin
        e = due_results.pop_front();
        if (got.kind !== e.kind) mismatch("result_kind", int'(e.kind), int'(got.kind));
        if (got.data !== e.data) mismatch("data_byte", int'(e.data), int'(got.data));
        if (got.opcode !== e.opcode) mismatch("is_opcode", int'(e.opcode), int'(got.opcode));
        if (got.last !== e.last) mismatch("is_last_body", int'(e.last), int'(got.last));
        if (got.err !== e.err) mismatch("error_code", int'(e.err), int'(got.err));
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [15:0]         out_tdata;
  logic [2:0]          out_tuser;
  logic                out_tlast;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  frame_tracker sb;
  bit           idle_on;
  bit           stall_req;
  int           hold_left;
  int           cycles;

  frame_deframer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result sink
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got        = '0;
      got.kind   = kind_t'(out_tuser[1:0]);
      got.data   = out_tdata[7:0];
      got.opcode = out_tuser[2];
      got.last   = out_tlast;
      got.err    = err_t'(out_tdata[10:8]);
      sb.check_out(got);
    end
  end

  // receiver ready, with a long hold-off on request
  always @(negedge clk) begin
    if (stall_req) begin
      stall_req <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= idle_on ? ($urandom_range(99) >= 17) : 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.advance_rx(b);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_max(input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MAX_LEN;
    pwdata  <= {16'h0000, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.max_len = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_max();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_MAX_LEN;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== sb.max_len)
      sb.mismatch("prdata", int'(sb.max_len), int'(prdata[15:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] other_than(logic [7:0] v);
    logic [7:0] r;
    r = 8'($urandom);
    while (r == v) r = 8'($urandom);
    return r;
  endfunction

  // fill: 0 random, 1 all zero, 2 all ones, 3 header/footer lookalikes
  function automatic logic [7:0] body_byte(int fill, int i);
    case (fill)
      1: return 8'h00;
      2: return 8'hFF;
      3: return i[0] ? 8'h55 : 8'hAA;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_head(input logic [15:0] len);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
  endtask

  task automatic send_frame(input logic [15:0] len, input int fill);
    send_head(len);
    for (int i = 0; i < len; i++) send_byte(body_byte(fill, i));
    send_byte(FTR_FIRST);
    send_byte(FTR_SECOND);
  endtask

  function automatic int pick_len(int mx);
    int hi;
    hi = (mx < 24) ? mx : 24;
    if (mx >= 256 && $urandom_range(19) == 0)
      return $urandom_range(256, (mx < 300) ? mx : 300);
    if (mx <= 300 && $urandom_range(9) == 0) return mx;
    return $urandom_range(1, hi);
  endfunction

  initial begin
    int          sent;
    int          mx;
    int          len;
    int          pick;
    logic [15:0] bad_len;
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_on    = 1'b1;
    stall_req  = 1'b0;
    hold_left  = 0;
    cycles     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed
    read_max();
    send_frame(16'd1, 2);
    send_frame(16'd2, 1);
    drain();
    write_max(16'd1);
    read_max();
    send_frame(16'd1, 3);
    drain();
    write_max(16'hFFFF);
    read_max();
    send_frame(16'd3, 3);

    // random phases
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: mx = 1;
        1: mx = 65535;
        3: mx = 257;
        default: mx = $urandom_range(2, 64);
      endcase
      write_max(mx[15:0]);
      read_max();
      idle_on = (p != 4);
      if (p == 2) stall_req = 1'b1;
      sent = 0;
      while (sent < 200) begin
        len = pick_len(mx);
        send_frame(len[15:0], 0);
        sent += len + 6;
      end
    end
    idle_on = 1'b1;

    // one framing error, then bytes that must be swallowed
    pick = $urandom_range(0, 5);
    case (pick)
      0: send_byte(other_than(HDR_FIRST));
      1: begin
        send_byte(HDR_FIRST);
        send_byte(other_than(HDR_SECOND));
      end
      2: send_head(16'd0);
      3: begin
        drain();
        mx = $urandom_range(1, 200);
        write_max(mx[15:0]);
        read_max();
        bad_len = 16'($urandom_range(mx + 1, 65535));
        send_head(bad_len);
      end
      4: begin
        send_head(16'd2);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_byte(other_than(FTR_FIRST));
        send_byte(8'($urandom));
      end
      default: begin
        send_head(16'd1);
        send_byte(8'($urandom));
        send_byte(FTR_FIRST);
        send_byte(other_than(FTR_SECOND));
      end
    endcase
    send_frame(16'd2, 0);
    for (int i = 0; i < 12; i++) send_byte(8'($urandom));

    in_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
